>>> design/u2u8_pkg.sv
`timescale 1ns / 1ps

package u2u8_pkg;

    // byte counter width
    localparam int CNT_W = 16;
    // count plus one bit for the capacity compare
    localparam int SUM_W = CNT_W + 1;

    localparam int CAP_W  = 16;
    localparam int UNIT_W = 16;
    localparam int CP_W   = 21;

    // command queue
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // configuration register indexes
    typedef enum logic [0:0] {
        REG_STRICT_MODE  = 1'b0,
        REG_OUT_CAPACITY = 1'b1
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_SRC_EXH = 2'd1,
        ST_SRC_ILL = 2'd2,
        ST_TGT_EXH = 2'd3
    } status_t;

    // one classified word: bytes of cp_a, then bytes of cp_b, then an optional status
    typedef struct packed {
        logic [CP_W-1:0]   cp_a;
        logic [2:0]        n_a;
        logic [UNIT_W-1:0] cp_b;
        logic [1:0]        n_b;
        logic              has_st;
        status_t           st;
    } cmd_t;

    // byte i of the n-byte UTF-8 form of cp
    function automatic logic [7:0] utf8_byte(input logic [CP_W-1:0] cp,
                                             input logic [2:0] n,
                                             input logic [1:0] i);
        logic [7:0] b;
        b = 8'h00;
        unique case (n)
            3'd1: b = {1'b0, cp[6:0]};
            3'd2: begin
                if (i == 2'd0) b = {3'b110, cp[10:6]};
                else           b = {2'b10, cp[5:0]};
            end
            3'd3: begin
                unique case (i)
                    2'd0:    b = {4'b1110, cp[15:12]};
                    2'd1:    b = {2'b10, cp[11:6]};
                    default: b = {2'b10, cp[5:0]};
                endcase
            end
            3'd4: begin
                unique case (i)
                    2'd0:    b = {5'b11110, cp[20:18]};
                    2'd1:    b = {2'b10, cp[17:12]};
                    2'd2:    b = {2'b10, cp[11:6]};
                    default: b = {2'b10, cp[5:0]};
                endcase
            end
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

>>> design/u2u8_front.sv
`timescale 1ns / 1ps

module u2u8_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [0:0]                    cfg_index,
    input  logic [u2u8_pkg::CAP_W-1:0]    cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [u2u8_pkg::UNIT_W-1:0]   s_code_unit,
    output logic                          push,
    output u2u8_pkg::cmd_t                push_cmd,
    input  logic                          q_full
);

    logic                          strict_reg;
    logic [u2u8_pkg::CAP_W-1:0]    cap_reg;
    logic [9:0]                    pend_high_reg, pend_high_next;
    logic                          pend_valid_reg, pend_valid_next;
    logic [u2u8_pkg::CNT_W-1:0]    bytes_reg, bytes_next;
    logic                          stopped_reg, stopped_next;

    logic                          fire;
    logic                          u_zero, u_high, u_low;
    logic [1:0]                    n_u;
    logic [u2u8_pkg::SUM_W-1:0]    cap_ext, lead_sum, fresh_base, fresh_sum;
    logic                          lead_fit, fresh_fit;
    u2u8_pkg::cmd_t                cmd;

    assign s_ready = !q_full;
    assign fire    = s_valid && !q_full;

    assign u_zero = (s_code_unit == '0);
    assign u_high = (s_code_unit[15:10] == 6'b110110);
    assign u_low  = (s_code_unit[15:10] == 6'b110111);

    always_comb begin
        if (s_code_unit[15:7] == '0)       n_u = 2'd1;
        else if (s_code_unit[15:11] == '0) n_u = 2'd2;
        else                               n_u = 2'd3;
    end

    // pair gives 4 bytes, a flushed lone high surrogate 3
    assign cap_ext    = u2u8_pkg::SUM_W'(cap_reg);
    assign lead_sum   = {1'b0, bytes_reg} + (u_low ? u2u8_pkg::SUM_W'(4)
                                                   : u2u8_pkg::SUM_W'(3));
    assign lead_fit   = (lead_sum <= cap_ext);
    assign fresh_base = pend_valid_reg ? lead_sum : {1'b0, bytes_reg};
    assign fresh_sum  = fresh_base + u2u8_pkg::SUM_W'(n_u);
    assign fresh_fit  = (fresh_sum <= cap_ext);

    always_comb begin
        pend_high_next  = pend_high_reg;
        pend_valid_next = pend_valid_reg;
        bytes_next      = bytes_reg;
        stopped_next    = stopped_reg;
        cmd             = '0;
        cmd.st          = u2u8_pkg::ST_OK;
        if (fire) begin
            priority if (stopped_reg) begin
                // drop until terminator
                if (u_zero) begin
                    pend_high_next  = '0;
                    pend_valid_next = 1'b0;
                    bytes_next      = '0;
                    stopped_next    = 1'b0;
                end
            end else if (u_zero) begin
                cmd.has_st      = 1'b1;
                cmd.st          = pend_valid_reg ? u2u8_pkg::ST_SRC_EXH : u2u8_pkg::ST_OK;
                pend_high_next  = '0;
                pend_valid_next = 1'b0;
                bytes_next      = '0;
            end else if (pend_valid_reg && u_low) begin
                pend_high_next  = '0;
                pend_valid_next = 1'b0;
                if (lead_fit) begin
                    cmd.cp_a   = u2u8_pkg::CP_W'(21'h10000)
                               + u2u8_pkg::CP_W'({pend_high_reg, s_code_unit[9:0]});
                    cmd.n_a    = 3'd4;
                    bytes_next = lead_sum[u2u8_pkg::CNT_W-1:0];
                end else begin
                    cmd.has_st   = 1'b1;
                    cmd.st       = u2u8_pkg::ST_TGT_EXH;
                    bytes_next   = '0;
                    stopped_next = 1'b1;
                end
            end else if (pend_valid_reg && strict_reg) begin
                cmd.has_st      = 1'b1;
                cmd.st          = u2u8_pkg::ST_SRC_ILL;
                pend_high_next  = '0;
                pend_valid_next = 1'b0;
                bytes_next      = '0;
                stopped_next    = 1'b1;
            end else if (pend_valid_reg && !lead_fit) begin
                cmd.has_st      = 1'b1;
                cmd.st          = u2u8_pkg::ST_TGT_EXH;
                pend_high_next  = '0;
                pend_valid_next = 1'b0;
                bytes_next      = '0;
                stopped_next    = 1'b1;
            end else begin
                // lenient flush of held high surrogate, then the unit as fresh
                if (pend_valid_reg) begin
                    cmd.cp_a = u2u8_pkg::CP_W'({6'b110110, pend_high_reg});
                    cmd.n_a  = 3'd3;
                end
                pend_high_next  = '0;
                pend_valid_next = 1'b0;
                bytes_next      = fresh_base[u2u8_pkg::CNT_W-1:0];
                priority if (u_high) begin
                    pend_high_next  = s_code_unit[9:0];
                    pend_valid_next = 1'b1;
                end else if (u_low && strict_reg) begin
                    cmd.has_st   = 1'b1;
                    cmd.st       = u2u8_pkg::ST_SRC_ILL;
                    bytes_next   = '0;
                    stopped_next = 1'b1;
                end else if (!fresh_fit) begin
                    cmd.has_st   = 1'b1;
                    cmd.st       = u2u8_pkg::ST_TGT_EXH;
                    bytes_next   = '0;
                    stopped_next = 1'b1;
                end else begin
                    cmd.cp_b   = s_code_unit;
                    cmd.n_b    = n_u;
                    bytes_next = fresh_sum[u2u8_pkg::CNT_W-1:0];
                end
            end
        end
    end

    assign push     = fire && ((cmd.n_a != '0) || (cmd.n_b != '0) || cmd.has_st);
    assign push_cmd = cmd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            strict_reg     <= 1'b1;
            cap_reg        <= u2u8_pkg::CAP_W'(256);
            pend_high_reg  <= '0;
            pend_valid_reg <= 1'b0;
            bytes_reg      <= '0;
            stopped_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (u2u8_pkg::reg_idx_t'(cfg_index))
                    u2u8_pkg::REG_STRICT_MODE:  strict_reg <= cfg_wdata[0];
                    u2u8_pkg::REG_OUT_CAPACITY: cap_reg    <= cfg_wdata;
                    default:                    strict_reg <= strict_reg;
                endcase
            end
            pend_high_reg  <= pend_high_next;
            pend_valid_reg <= pend_valid_next;
            bytes_reg      <= bytes_next;
            stopped_reg    <= stopped_next;
        end
    end

endmodule

>>> design/u2u8_fifo.sv
`timescale 1ns / 1ps

module u2u8_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  u2u8_pkg::cmd_t  push_cmd,
    output logic            full,
    input  logic            pop,
    output logic            empty,
    output u2u8_pkg::cmd_t  head
);

    u2u8_pkg::cmd_t                mem_reg [u2u8_pkg::Q_DEPTH];
    logic [u2u8_pkg::Q_AW-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [u2u8_pkg::Q_CW-1:0]     count_reg, count_next;

    assign full  = (count_reg == u2u8_pkg::Q_CW'(u2u8_pkg::Q_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop)      count_next = count_reg + 1'b1;
        else if (pop && !push) count_next = count_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && empty))
        else $error("queue pop while empty");

endmodule

>>> design/u2u8_back.sv
`timescale 1ns / 1ps

module u2u8_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            empty,
    input  u2u8_pkg::cmd_t  head,
    output logic            pop,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [7:0]      m_out_byte,
    output logic            m_byte_valid,
    output logic [1:0]      m_status,
    output logic            m_end_of_string
);

    logic [2:0]   idx_reg;
    logic [2:0]   total, n_ab, idx_b;
    logic         last, advance;
    logic [7:0]   item_byte;
    logic         item_bv, item_eos;
    logic [1:0]   item_st;

    logic         m_valid_reg;
    logic [7:0]   m_out_byte_reg;
    logic         m_byte_valid_reg;
    logic [1:0]   m_status_reg;
    logic         m_end_of_string_reg;

    assign n_ab  = head.n_a + {1'b0, head.n_b};
    assign total = n_ab + {2'b0, head.has_st};
    assign idx_b = idx_reg - head.n_a;
    assign last  = (idx_reg == total - 3'd1);

    assign advance = !empty && (!m_valid_reg || m_ready);
    assign pop     = advance && last;

    always_comb begin
        item_byte = 8'h00;
        item_bv   = 1'b0;
        item_st   = u2u8_pkg::ST_OK;
        item_eos  = 1'b0;
        priority if (idx_reg < head.n_a) begin
            item_byte = u2u8_pkg::utf8_byte(head.cp_a, head.n_a, idx_reg[1:0]);
            item_bv   = 1'b1;
        end else if (idx_reg < n_ab) begin
            item_byte = u2u8_pkg::utf8_byte(u2u8_pkg::CP_W'(head.cp_b),
                                            {1'b0, head.n_b}, idx_b[1:0]);
            item_bv   = 1'b1;
        end else begin
            item_st  = head.st;
            item_eos = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (advance) idx_reg <= last ? 3'd0 : idx_reg + 3'd1;
            if (advance)      m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_out_byte_reg      <= item_byte;
            m_byte_valid_reg    <= item_bv;
            m_status_reg        <= item_st;
            m_end_of_string_reg <= item_eos;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_out_byte      = m_out_byte_reg;
    assign m_byte_valid    = m_byte_valid_reg;
    assign m_status        = m_status_reg;
    assign m_end_of_string = m_end_of_string_reg;

    a_idx_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        !empty |-> (idx_reg < total))
        else $error("item index past end of queued word");

    a_idx_home_on_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        empty |-> (idx_reg == 3'd0))
        else $error("item index not cleared while queue empty");

endmodule

>>> design/utf16_to_utf8_stream.sv
`timescale 1ns / 1ps

// channel   direction  handshake          payload
// s_        in         s_valid/s_ready    s_code_unit[15:0]
// m_        out        m_valid/m_ready    m_out_byte[7:0] m_byte_valid m_status[1:0]
//                                         m_end_of_string
// cfg_      in         cfg_wr_en          cfg_index[0] cfg_wdata[15:0]
//
// One code unit is taken per cycle while the 4-entry command queue has room.
// Output runs at one word per cycle; a unit yields 0 to 6 words, so the
// sustained input rate is set by the back end's single output register.
// An accepted unit's command is registered in the queue, then its first word in the back end's output register.
// aresetn is synchronous, active low: strict mode on, capacity 256, state clear.
// Input and output stall independently; the queue absorbs up to 4 commands.

module utf16_to_utf8_stream (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [0:0]                    cfg_index,
    input  logic [u2u8_pkg::CAP_W-1:0]    cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [u2u8_pkg::UNIT_W-1:0]   s_code_unit,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [7:0]                    m_out_byte,
    output logic                          m_byte_valid,
    output logic [1:0]                    m_status,
    output logic                          m_end_of_string
);

    // front -> queue
    logic            q_push;
    u2u8_pkg::cmd_t  q_push_cmd;
    logic            q_full;
    // queue -> back
    logic            q_pop;
    logic            q_empty;
    u2u8_pkg::cmd_t  q_head;

    // front: surrogate pairing, byte counting, error and discard state
    u2u8_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_code_unit (s_code_unit),
        .push        (q_push),
        .push_cmd    (q_push_cmd),
        .q_full      (q_full)
    );

    // queue of classified commands
    u2u8_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (q_push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head     (q_head)
    );

    // back: serializes each command into UTF-8 bytes and an optional status word
    u2u8_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .empty           (q_empty),
        .head            (q_head),
        .pop             (q_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_byte      (m_out_byte),
        .m_byte_valid    (m_byte_valid),
        .m_status        (m_status),
        .m_end_of_string (m_end_of_string)
    );

endmodule
